@@ hdl/hps_pitch_peak_finder_top_defines.svh @@
// Assertion macros used by the checker file of the pitch peak finder.
`ifndef HPS_PITCH_PEAK_FINDER_TOP_DEFINES_SVH
`define HPS_PITCH_PEAK_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk and muted while reset is held.
`define HPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and muted while reset is held.
`define HPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hps_pkg.sv @@
// Shared types and constants of the harmonic product spectrum pitch peak finder.
package hps_pkg;

    localparam int MAG_W   = 16;
    localparam int PEAK_W  = 11;
    localparam int PROD_W  = 48;
    localparam int BAND_W  = 12;
    localparam int IDX_W   = 13;
    localparam int MUL_A_W = 32;

    localparam logic [BAND_W-1:0] BAND_LOW_RST  = 12'd14;
    localparam logic [BAND_W-1:0] BAND_HIGH_RST = 12'd186;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_BAND_LOW  = 1'b0;
    localparam logic REG_BAND_HIGH = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last_bin;
    } in_word_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_bin;
        logic [PROD_W-1:0] peak_value;
        logic              all_zero;
    } out_word_t;

endpackage

@@ hdl/hps_pitch_peak_finder_top.sv @@
// Top level of the three-harmonic product spectrum pitch peak finder.
//
// The block takes one window of spectrum magnitude words, one bin per word from
// bin zero, with last_bin set on the final word. Only the first WINDOW_LEN/2 bins
// are kept; later words before the mark are accepted and dropped. Loading runs at
// one word per cycle. When the marked word is taken, s_ready drops and a sequencer
// walks k = 0, 1, ... while 3k < WINDOW_LEN/2. For each k it reads bins k, 2k and
// 3k through the single read port of the bin store, zeroes any bin that lies
// outside [band_low, band_high] or was not loaded in this window, and forms
// X[k]*X[2k]*X[3k] in two passes through one shared 32x16 multiplier. Each k steps
// through the states issue k, issue 2k, issue 3k, multiply and compare in turn, as
// the single read port and the shared multiplier allow. The search always walks
// every k up to the half window, so a short window still walks all of them. The
// finished result moves into an output register that holds it on m_valid: the
// lowest k of the largest product, that product, and all_zero when every product
// was zero (peak_bin is 0 then). The block takes the next window at once; a second
// finished search waits, with s_ready low, until the output register is free. An
// inverted band zeroes every bin. The band registers sit on an APB-style port at
// byte addresses 0 (band_low) and 4 (band_high) and should be written only while
// the block is idle.
module hps_pitch_peak_finder_top #(
    parameter int WINDOW_LEN = 8192
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  hps_pkg::in_word_t  s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output hps_pkg::out_word_t m_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hps_pkg::*;

    localparam int HALF   = WINDOW_LEN / 2;
    localparam int ADDR_W = $clog2(HALF);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF);
    localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF);

    // One-hot sequencer. The three issue states drive the read address; the
    // data of each read arrives one state later.
    typedef enum logic [6:0] {
        ST_LOAD     = 7'b0000001,
        ST_ISSUE_K  = 7'b0000010,
        ST_ISSUE_2K = 7'b0000100,
        ST_ISSUE_3K = 7'b0001000,
        ST_MUL_3K   = 7'b0010000,
        ST_CMP      = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [BAND_W-1:0] band_low_reg, band_low_next;
    logic [BAND_W-1:0] band_high_reg, band_high_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [PEAK_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]  k2_reg, k2_next;
    logic [IDX_W-1:0]  k3_reg, k3_next;
    logic [PEAK_W-1:0] best_index_reg, best_index_next;
    logic [PROD_W-1:0] best_product_reg, best_product_next;
    logic [MAG_W-1:0]  opa_reg, opa_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              keep_reg, keep_next;
    out_word_t         result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic              cfg_write;
    logic              in_accept;
    logic              store_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [MAG_W-1:0]  rd_data;
    logic [MAG_W-1:0]  bin_val;
    logic [MUL_A_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_p;
    logic              last_k;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // combinational since pready is tied high.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        band_low_next  = band_low_reg;
        band_high_next = band_high_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_BAND_LOW:  band_low_next  = pwdata[BAND_W-1:0];
                REG_BAND_HIGH: band_high_next = pwdata[BAND_W-1:0];
                default:       band_low_next  = band_low_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BAND_LOW:  prdata = 32'(band_low_reg);
            REG_BAND_HIGH: prdata = 32'(band_high_reg);
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Bin store. Words past the half window are accepted but not written.
    // ------------------------------------------------------------------
    assign s_ready   = (state_reg == ST_LOAD);
    assign in_accept = s_valid && s_ready;
    assign store_en  = in_accept && (load_count_reg < HALF_CNT);

    always_comb begin
        unique case (state_reg)
            ST_ISSUE_2K: rd_idx = k2_reg;
            ST_ISSUE_3K: rd_idx = k3_reg;
            default:     rd_idx = IDX_W'(k_reg);
        endcase
    end

    hps_bin_ram #(
        .ADDR_W (ADDR_W)
    ) u_bin_ram (
        .aclk    (aclk),
        .wr_en   (store_en),
        .wr_addr (load_count_reg[ADDR_W-1:0]),
        .wr_data (s_data.magnitude),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // The keep flag travels alongside the registered read: a bin counts only if
    // it was loaded in this window and lies inside the band.
    assign keep_next = (rd_idx < IDX_W'(load_count_reg))
                    && (rd_idx >= IDX_W'(band_low_reg))
                    && (rd_idx <= IDX_W'(band_high_reg));
    assign bin_val   = keep_reg ? rd_data : '0;

    // ------------------------------------------------------------------
    // Shared multiplier: X[k]*X[2k] in one pass, that product times X[3k]
    // in the next. The operands are 32 and 16 bits, so the product fits
    // the full 48-bit result.
    // ------------------------------------------------------------------
    assign mul_a  = (state_reg == ST_MUL_3K) ? prod_reg[MUL_A_W-1:0] : MUL_A_W'(opa_reg);
    assign mul_p  = PROD_W'(mul_a) * PROD_W'(bin_val);
    assign last_k = (k3_reg + IDX_W'(3)) >= HALF_IDX;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        load_count_next   = load_count_reg;
        k_next            = k_reg;
        k2_next           = k2_reg;
        k3_next           = k3_reg;
        best_index_next   = best_index_reg;
        best_product_next = best_product_reg;
        opa_next          = opa_reg;
        prod_next         = prod_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        // A result word taken by the receiver frees the output register.
        if (result_valid_reg && m_ready) begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (store_en) begin
                    load_count_next = load_count_reg + CNT_W'(1);
                end
                if (in_accept && s_data.last_bin) begin
                    k_next            = '0;
                    k2_next           = '0;
                    k3_next           = '0;
                    best_index_next   = '0;
                    best_product_next = '0;
                    state_next        = ST_ISSUE_K;
                end
            end
            ST_ISSUE_K: begin
                state_next = ST_ISSUE_2K;
            end
            ST_ISSUE_2K: begin
                opa_next   = bin_val;
                state_next = ST_ISSUE_3K;
            end
            ST_ISSUE_3K: begin
                prod_next  = mul_p;
                state_next = ST_MUL_3K;
            end
            ST_MUL_3K: begin
                prod_next  = mul_p;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // Strictly greater keeps the lowest k on ties.
                if (prod_reg > best_product_reg) begin
                    best_product_next = prod_reg;
                    best_index_next   = k_reg;
                end
                if (last_k) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = k_reg + PEAK_W'(1);
                    k2_next    = k2_reg + IDX_W'(2);
                    k3_next    = k3_reg + IDX_W'(3);
                    state_next = ST_ISSUE_K;
                end
            end
            ST_OUT: begin
                // Hand the result over as soon as the output register is free.
                if (!result_valid_reg || m_ready) begin
                    result_next.peak_bin   = best_index_reg;
                    result_next.peak_value = best_product_reg;
                    result_next.all_zero   = (best_product_reg == '0);
                    result_valid_next      = 1'b1;
                    load_count_next        = '0;
                    state_next             = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            band_low_reg     <= BAND_LOW_RST;
            band_high_reg    <= BAND_HIGH_RST;
            load_count_reg   <= '0;
            best_index_reg   <= '0;
            best_product_reg <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            band_low_reg     <= band_low_next;
            band_high_reg    <= band_high_next;
            load_count_reg   <= load_count_next;
            best_index_reg   <= best_index_next;
            best_product_reg <= best_product_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        k2_reg   <= k2_next;
        k3_reg   <= k3_next;
        opa_reg  <= opa_next;
        prod_reg <= prod_next;
        keep_reg <= keep_next;
    end

    // The result word is held in the output register until it is taken.
    assign m_valid = result_valid_reg;
    assign m_data  = result_reg;

endmodule

@@ hdl/hps_bin_ram.sv @@
// Simple dual-port bin store with one write port and one registered read port.
module hps_bin_ram #(
    parameter int ADDR_W = 12
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [hps_pkg::MAG_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [hps_pkg::MAG_W-1:0] rd_data
);
    import hps_pkg::*;

    logic [MAG_W-1:0] mem [2**ADDR_W];
    logic [MAG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/hps_checker.sv @@
// Port-level checker of the pitch peak finder and its bind to the top level.
`include "hps_pitch_peak_finder_top_defines.svh"

module hps_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input hps_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input hps_pkg::out_word_t m_data
);
    import hps_pkg::*;

    // The input side stays ready until the closing word of a window is taken.
    `HPS_ASSERT_NEXT(a_ready_until_last, s_ready && !(s_valid && s_data.last_bin), s_ready,
        "input ready dropped without a last bin")

    // The closing word of a window starts the search, so input stalls next.
    `HPS_ASSERT_NEXT(a_stall_after_last, s_valid && s_ready && s_data.last_bin, !s_ready,
        "input still ready after the last bin")

    // An all-zero spectrum reports bin zero and a zero product.
    `HPS_ASSERT_NOW(a_all_zero_result, m_valid && m_data.all_zero,
        (m_data.peak_bin == '0) && (m_data.peak_value == '0), "all-zero result is not zero")

    // A nonzero product never carries the all-zero flag.
    `HPS_ASSERT_NOW(a_nonzero_flag, m_valid && (m_data.peak_value != '0), !m_data.all_zero,
        "all_zero set with a nonzero peak")

    // A stalled result word holds.
    `HPS_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data),
        "result word changed while stalled")

endmodule

bind hps_pitch_peak_finder_top hps_checker u_hps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ bench/tb_top.sv @@
// Self-checking testbench for the three-harmonic product spectrum pitch peak finder.
`timescale 1ns / 1ps

module tb_top;

    import hps_pkg::*;

    // The block runs at its default window length. The half window sets how many bins are
    // kept and how far the search over k reaches.
    localparam int          WIN_LEN     = 8192;
    localparam int unsigned HALF_LEN    = WIN_LEN / 2;
    localparam int unsigned BIN_DEPTH   = 4096;

    // One search walks about HALF_LEN/3 values of k, whatever the window length.
    // SETTLE_CYCLES covers the tail after the last result, and the receiver's long hold
    // outlasts two searches, so one result sits in the output register, a second waits
    // behind it, and the block drops s_ready.
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned HOLD_CYCLES   = 24000;
    localparam int unsigned LIMIT_CYCLES  = 20000000;
    localparam int unsigned MAX_REPORTS   = 10;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;

    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Bench copy of the bin store, the load count and the band registers. The band copy
    // changes only at the write edge of the configuration port.
    logic [MAG_W-1:0]  spectrum_bins [0:BIN_DEPTH-1];
    int unsigned       bins_loaded = 0;
    logic [BAND_W-1:0] band_lo_q   = BAND_LOW_RST;
    logic [BAND_W-1:0] band_hi_q   = BAND_HIGH_RST;

    // Peaks predicted at each marked word and not yet seen on the result channel.
    out_word_t   pending_peaks [$];

    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned words_sent   = 0;
    int unsigned windows_sent = 0;

    // When set, the sender offers words back to back with no gaps.
    bit tx_burst    = 1'b0;
    // When set, the receiver holds m_ready low for HOLD_CYCLES, counted in its own process.
    bit rx_hold_req = 1'b0;

    hps_pitch_peak_finder_top #(
        .WINDOW_LEN(WIN_LEN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d peaks still pending",
                     cycle_count, pending_peaks.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle length shared by both sides: mostly none, often a few cycles, now and then long.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Magnitude mix: tiny values make ties common, full-scale and random words cover every
    // bit, and zeros punch holes in the products.
    function automatic logic [MAG_W-1:0] pick_magnitude();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return MAG_W'($urandom_range(0, 3));
        if (roll < 70)
            return MAG_W'($urandom);
        if (roll < 80)
            return '0;
        if (roll < 90)
            return '1;
        return MAG_W'($urandom_range(1, 255));
    endfunction

    // Band-filtered value of one bin: bins not loaded in this window and bins outside the
    // band count as zero.
    function automatic longint unsigned kept_bin(int unsigned idx);
        if (idx >= bins_loaded || idx >= BIN_DEPTH)
            return 0;
        if (idx < band_lo_q || idx > band_hi_q)
            return 0;
        return longint'(spectrum_bins[idx]);
    endfunction

    // Predicted peak of the loaded window: the lowest k holding the largest three-fold
    // harmonic product, that product, and the all-zero flag.
    function automatic out_word_t hps_peak();
        out_word_t         peak;
        longint unsigned   best;
        longint unsigned   prod;
        int unsigned       best_k;
        int unsigned       k;
        best   = 0;
        best_k = 0;
        for (k = 0; 3 * k < HALF_LEN; k++) begin
            prod = kept_bin(k) * kept_bin(2 * k) * kept_bin(3 * k);
            prod = prod & ((64'd1 << PROD_W) - 1);
            if (prod > best) begin
                best   = prod;
                best_k = k;
            end
        end
        peak.peak_bin   = best_k[PEAK_W-1:0];
        peak.peak_value = best[PROD_W-1:0];
        peak.all_zero   = (best == 0);
        return peak;
    endfunction

    // Both channels are sampled here at the rising edge. An accepted input word updates the
    // bench copy of the store; a marked word queues the predicted peak and starts a fresh
    // window. An accepted result word is checked against the oldest predicted peak.
    always @(posedge aclk) begin : watch_ports
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                // Only the first half window is stored; later words before the mark drop.
                if (bins_loaded < HALF_LEN && bins_loaded < BIN_DEPTH) begin
                    spectrum_bins[bins_loaded] = s_data.magnitude;
                    bins_loaded = bins_loaded + 1;
                end
                if (s_data.last_bin) begin
                    pending_peaks = {pending_peaks, hps_peak()};
                    bins_loaded = 0;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_peaks.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected result: bin %0d value %0d zero %0b",
                                 m_data.peak_bin, m_data.peak_value, m_data.all_zero);
                end else begin
                    want = pending_peaks.pop_front();
                    if (m_data.peak_bin !== want.peak_bin ||
                            m_data.peak_value !== want.peak_value ||
                            m_data.all_zero !== want.all_zero) begin
                        error_count = error_count + 1;
                        if (error_count <= MAX_REPORTS)
                            $display("ERROR: peak exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     want.peak_bin, want.peak_value, want.all_zero,
                                     m_data.peak_bin, m_data.peak_value, m_data.all_zero);
                    end
                end
            end
        end
    end

    // Receiver: random stalls and runs of readiness, plus the long hold on request. The
    // hold is checked every cycle so that it takes effect at once.
    initial begin : result_receiver
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned hold_count;
        stall_left = 0;
        run_left   = 0;
        hold_count = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready    = 1'b0;
                hold_count = hold_count + 1;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_count  = 0;
                    rx_hold_req = 1'b0;
                end
            end else if (stall_left > 0) begin
                m_ready    = 1'b0;
                stall_left = stall_left - 1;
            end else if (run_left > 0) begin
                m_ready  = 1'b1;
                run_left = run_left - 1;
            end else begin
                // Pick the next stall and the run of readiness after it; some runs are long
                // stretches with no stalls at all.
                stall_left = idle_len();
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
                m_ready    = (stall_left == 0);
            end
        end
    end

    // Sends one bin word. Inputs change at the falling edge; the task returns just after
    // the rising edge that accepted the word, with s_valid still high so that a following
    // word can go out back to back.
    task automatic send_bin(input logic [MAG_W-1:0] magnitude, input logic last_bin);
        int unsigned gap;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid          = 1'b1;
        s_data.magnitude = magnitude;
        s_data.last_bin  = last_bin;
        do
            @(posedge aclk);
        while (!s_ready);
        words_sent = words_sent + 1;
        if (last_bin)
            windows_sent = windows_sent + 1;
    endtask

    // Lowers s_valid and waits until every predicted peak has been checked. The first
    // falling edge also lets the monitor record a word accepted at the edge just passed.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_peaks.size() != 0)
            @(negedge aclk);
    endtask

    // Reads one band register back through the configuration port.
    task automatic read_band(input logic reg_sel, input logic [BAND_W-1:0] want);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {reg_sel, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (prdata[BAND_W-1:0] !== want) begin
            error_count = error_count + 1;
            if (error_count <= MAX_REPORTS)
                $display("ERROR: band register %0d read back %0d, expected %0d",
                         reg_sel, prdata[BAND_W-1:0], want);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes one band register (setup then access cycle) and reads it back.
    task automatic write_band(input logic reg_sel, input logic [BAND_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = {{(32 - BAND_W){1'b0}}, value};
        @(negedge aclk);
        penable = 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (reg_sel == REG_BAND_LOW)
            band_lo_q = value;
        else
            band_hi_q = value;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        read_band(reg_sel, value);
    endtask

    // Band changes happen only with the block idle: every peak is in, and the tail of the
    // search has had time to settle.
    task automatic set_band(input logic [BAND_W-1:0] lo, input logic [BAND_W-1:0] hi);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_band(REG_BAND_LOW, lo);
        write_band(REG_BAND_HIGH, hi);
    endtask

    // One window of random content; window lengths are mostly short so that the search
    // pass, not the load, sets the pace, with a few longer ones.
    task automatic send_random_window();
        int unsigned roll;
        int unsigned len;
        int unsigned i;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            len = $urandom_range(1, 12);
        else if (roll < 97)
            len = $urandom_range(13, 48);
        else
            len = $urandom_range(49, 200);
        tx_burst = ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++)
            send_bin(pick_magnitude(), i == len - 1);
        tx_burst = 1'b0;
    endtask

    // Reset values of the band registers, and a short window of full-scale bins that all
    // fall below the default band, so every product is zero.
    task automatic test_reset_band();
        int unsigned i;
        read_band(REG_BAND_LOW, BAND_LOW_RST);
        read_band(REG_BAND_HIGH, BAND_HIGH_RST);
        for (i = 0; i < 4; i++)
            send_bin('1, i == 3);
    endtask

    // With the band wide open, a single full-scale bin gives the largest product at k = 0,
    // and a single zero bin gives the all-zero result.
    task automatic test_single_bin_extremes();
        set_band('0, '1);
        send_bin('1, 1'b1);
        send_bin('0, 1'b1);
    endtask

    // Two equal products at k = 1 and k = 2: the lower k must win. The short window after
    // it must not see the bins of the previous window.
    task automatic test_tie_and_short_window();
        logic [MAG_W-1:0] tie_bins [0:6];
        int unsigned      i;
        tie_bins = '{16'd0, 16'd2, 16'd2, 16'd2, 16'd2, 16'd0, 16'd2};
        for (i = 0; i < 7; i++)
            send_bin(tie_bins[i], i == 6);
        send_bin(16'd0, 1'b0);
        send_bin(16'd5, 1'b1);
    endtask

    // An inverted band zeroes every bin; a band of bin zero alone keeps only k = 0.
    task automatic test_inverted_band();
        int unsigned i;
        set_band(12'd10, 12'd9);
        for (i = 0; i < 4; i++)
            send_bin('1, i == 3);
        set_band('0, '0);
        send_bin(16'd7, 1'b0);
        send_bin(16'd1, 1'b0);
        send_bin(16'd1, 1'b1);
    endtask

    // Full-scale bins at k, 2k and 3k over small noise put the peak at the top of the
    // 48-bit product range.
    task automatic test_full_scale_peak();
        int unsigned      i;
        int unsigned      peak_k;
        logic [MAG_W-1:0] magnitude;
        set_band('0, '1);
        peak_k = $urandom_range(10, 30);
        for (i = 0; i <= 3 * peak_k; i++) begin
            if (i == peak_k || i == 2 * peak_k || i == 3 * peak_k)
                magnitude = '1;
            else
                magnitude = MAG_W'($urandom_range(0, 40));
            send_bin(magnitude, i == 3 * peak_k);
        end
    endtask

    // Random windows over a series of band settings, the register extremes among them.
    // The last setting keeps running until enough windows have been sent.
    task automatic test_random_traffic();
        logic [BAND_W-1:0] band_lo_set [0:6];
        logic [BAND_W-1:0] band_hi_set [0:6];
        int unsigned       phase;
        int unsigned       start_words;
        int unsigned       start_windows;
        band_lo_set = '{12'd0, 12'd0,  12'd1,  12'd2,   12'd4095, 12'd0, 12'd0};
        band_hi_set = '{12'd4095, 12'd60, 12'd30, 12'd200, 12'd4095, 12'd0, 12'd0};
        // The last phase gets a random band near the bottom of the spectrum.
        band_lo_set[6] = BAND_W'($urandom_range(0, 20));
        band_hi_set[6] = BAND_W'($urandom_range(band_lo_set[6], 300));
        start_windows  = windows_sent;
        for (phase = 0; phase < 7; phase++) begin
            set_band(band_lo_set[phase], band_hi_set[phase]);
            start_words = words_sent;
            while (words_sent - start_words < 50)
                send_random_window();
        end
        while (windows_sent - start_windows < 30)
            send_random_window();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering windows, so
    // the block fills its output register, finishes a second search and stalls its input.
    // Afterwards the sender pauses until every peak is in before it sends one more window.
    task automatic test_result_backpressure();
        int unsigned i;
        set_band('0, 12'd100);
        rx_hold_req = 1'b1;
        for (i = 0; i < 3; i++)
            send_random_window();
        drain_results();
        send_random_window();
    endtask

    initial begin : run_tests
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_band();
        test_single_bin_extremes();
        test_tie_and_short_window();
        test_inverted_band();
        test_full_scale_peak();
        test_random_traffic();
        test_result_backpressure();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_peaks.size() != 0)
            error_count = error_count + 1;

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
